// ----- src/cube_rotation_grid_transform_unit_core_macros.svh -----
// assertion macros shared by the checker of the cube rotation transform unit
// expects clk and rst_n in the scope where a macro is used
`ifndef CUBE_ROTATION_GRID_TRANSFORM_UNIT_CORE_MACROS_SVH
`define CUBE_ROTATION_GRID_TRANSFORM_UNIT_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CRGT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent from the next cycle on
`define CRGT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/crgt_pkg.sv -----
// types, constants and rotation helpers for the cube rotation transform unit
// no dependencies; used by the input stage, the datapath and the top level
`timescale 1ns / 1ps

package crgt_pkg;

    localparam int COORD_BITS = 32;
    localparam int PORT_BITS  = 32;
    localparam int WIDE_BITS  = COORD_BITS + 2;
    localparam int LIM_BITS   = 31;
    localparam int ROT_IN_BITS = 8;
    localparam int ROT_BITS   = 5;
    localparam int NUM_ROT    = 24;

    localparam logic [LIM_BITS-1:0] LIM_CAP =
        LIM_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);

    // operation codes
    localparam logic [2:0] FUNC_ROTATE  = 3'd0;
    localparam logic [2:0] FUNC_APPLY   = 3'd1;
    localparam logic [2:0] FUNC_COMPOSE = 3'd2;
    localparam logic [2:0] FUNC_INVERSE = 3'd3;
    localparam logic [2:0] FUNC_ADD     = 3'd4;
    localparam logic [2:0] FUNC_SUB     = 3'd5;

    // signed unit axes: +x +y +z -x -y -z
    localparam logic [2:0] AXIS_NEG_X = 3'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic signed [PORT_BITS-1:0]  port_coord_t;
    typedef logic [2:0]                   axis_t;
    typedef logic [ROT_BITS-1:0]          rot_t;

    // matrix columns as signed axes
    typedef struct packed {
        axis_t x;
        axis_t y;
        axis_t z;
    } rot_cols_t;

    typedef struct packed {
        logic [2:0]             func;
        coord_t [2:0]           a;
        logic [ROT_IN_BITS-1:0] a_rot;
        coord_t [2:0]           b;
        logic [ROT_IN_BITS-1:0] b_rot;
    } item_t;

    typedef struct packed {
        logic        ok;
        port_coord_t x;
        port_coord_t y;
        port_coord_t z;
        rot_t        rot;
    } result_t;

    function automatic axis_t axis_neg(axis_t e);
        return (e < AXIS_NEG_X) ? e + AXIS_NEG_X : e - AXIS_NEG_X;
    endfunction

    function automatic logic [1:0] axis_base(axis_t e);
        axis_t t;
        t = (e < AXIS_NEG_X) ? e : e - AXIS_NEG_X;
        return t[1:0];
    endfunction

    function automatic axis_t axis_cross(axis_t a, axis_t b);
        logic [1:0] ba;
        logic [1:0] bb;
        logic [1:0] bc;
        logic       cyclic;
        logic       neg;
        ba = axis_base(a);
        bb = axis_base(b);
        bc = 2'd3 - ba - bb;
        cyclic = (bb == ((ba == 2'd2) ? 2'd0 : ba + 2'd1));
        neg = (a >= AXIS_NEG_X) ^ (b >= AXIS_NEG_X) ^ !cyclic;
        return {1'b0, bc} + (neg ? AXIS_NEG_X : 3'd0);
    endfunction

    // table order: x over the six axes, then y over the axes orthogonal to x
    function automatic rot_cols_t rot_cols(rot_t idx);
        rot_cols_t  c;
        axis_t      j;
        logic [1:0] b;
        b = axis_base(idx[4:2]);
        j = {1'b0, idx[1:0]};
        if (j >= {1'b0, b})
            j = j + 3'd1;
        if (j >= {1'b0, b} + AXIS_NEG_X)
            j = j + 3'd1;
        c.x = idx[4:2];
        c.y = j;
        c.z = axis_cross(idx[4:2], j);
        return c;
    endfunction

    function automatic rot_t rot_index(axis_t x, axis_t y);
        logic [1:0] b;
        axis_t      rank;
        b = axis_base(x);
        rank = y - ((y > {1'b0, b}) ? 3'd1 : 3'd0)
                 - ((y > {1'b0, b} + AXIS_NEG_X) ? 3'd1 : 3'd0);
        return {x, rank[1:0]};
    endfunction

    // image of a signed axis under a rotation
    function automatic axis_t rot_axis(rot_cols_t c, axis_t e);
        axis_t col;
        case (axis_base(e))
            2'd0:    col = c.x;
            2'd1:    col = c.y;
            default: col = c.z;
        endcase
        return (e >= AXIS_NEG_X) ? axis_neg(col) : col;
    endfunction

    function automatic rot_cols_t rot_transpose(rot_cols_t c);
        axis_t     cols [3];
        axis_t     tr [3];
        rot_cols_t r;
        cols[0] = c.x;
        cols[1] = c.y;
        cols[2] = c.z;
        for (int k = 0; k < 3; k++)
            tr[k] = '0;
        for (int k = 0; k < 3; k++)
            tr[axis_base(cols[k])] = 3'(k) + ((cols[k] >= AXIS_NEG_X) ? AXIS_NEG_X : 3'd0);
        r.x = tr[0];
        r.y = tr[1];
        r.z = tr[2];
        return r;
    endfunction

endpackage

// ----- src/crgt_in_stage.sv -----
// input register of the cube rotation transform unit
// depends on crgt_pkg
`timescale 1ns / 1ps

module crgt_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  crgt_pkg::item_t item,
    output logic           valid,
    output crgt_pkg::item_t item_q
);
    import crgt_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    assign valid  = valid_reg;
    assign item_q = item_reg;

endmodule

// ----- src/crgt_compute.sv -----
// single-pass datapath: signed permutation mux, adders and range checks
// depends on crgt_pkg
`timescale 1ns / 1ps

module crgt_compute (
    input  crgt_pkg::item_t           item,
    input  logic [crgt_pkg::LIM_BITS-1:0] max_coord,
    output crgt_pkg::result_t         result
);
    import crgt_pkg::*;

    localparam coord_t COORD_BAD = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [LIM_BITS-1:0] lim_cap;
    wide_t     lim;
    wide_t     a_w [3];
    wide_t     b_w [3];
    wide_t     rb [3];
    wide_t     inv [3];
    wide_t     sum_ab [3];
    wide_t     add_ab [3];
    wide_t     sub_ab [3];
    wide_t     res [3];
    axis_t     acol [3];
    rot_cols_t rot_a;
    rot_cols_t rot_b;
    rot_cols_t rot_t_a;
    logic      a_ok;
    logic      b_ok;
    logic      arot_ok;
    logic      brot_ok;
    logic      rb_in;
    logic      inv_in;
    logic      sum_in;
    logic      add_in;
    logic      sub_in;
    logic      ok;
    rot_t      rot;
    coord_t    rx;
    coord_t    ry;
    coord_t    rz;

    function automatic logic in_lim(wide_t v, wide_t l);
        return (v <= l) && (v >= -l);
    endfunction

    assign lim_cap = (max_coord > LIM_CAP) ? LIM_CAP : max_coord;
    assign lim     = $signed({3'b000, lim_cap[COORD_BITS-2:0]});

    assign arot_ok = item.a_rot < ROT_IN_BITS'(NUM_ROT);
    assign brot_ok = item.b_rot < ROT_IN_BITS'(NUM_ROT);
    assign rot_a   = rot_cols(item.a_rot[ROT_BITS-1:0]);
    assign rot_b   = rot_cols(item.b_rot[ROT_BITS-1:0]);
    assign rot_t_a = rot_transpose(rot_a);
    assign acol[0] = rot_a.x;
    assign acol[1] = rot_a.y;
    assign acol[2] = rot_a.z;

    always_comb
    begin
        a_ok = 1'b1;
        b_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            a_w[i] = WIDE_BITS'($signed(item.a[i]));
            b_w[i] = WIDE_BITS'($signed(item.b[i]));
            if (item.a[i] == COORD_BAD)
                a_ok = 1'b0;
            if (item.b[i] == COORD_BAD)
                b_ok = 1'b0;
        end
    end

    // column k of the matrix lands input coordinate k on one output row
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            rb[i]  = '0;
            inv[i] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            rb[axis_base(acol[k])] = (acol[k] >= AXIS_NEG_X) ? -b_w[k] : b_w[k];
            // transpose applied to the negated translation
            inv[k] = (acol[k] >= AXIS_NEG_X) ? a_w[axis_base(acol[k])]
                                             : -a_w[axis_base(acol[k])];
        end
    end

    always_comb
    begin
        rb_in  = 1'b1;
        inv_in = 1'b1;
        sum_in = 1'b1;
        add_in = 1'b1;
        sub_in = 1'b1;
        for (int i = 0; i < 3; i++) begin
            sum_ab[i] = a_w[i] + rb[i];
            add_ab[i] = a_w[i] + b_w[i];
            sub_ab[i] = a_w[i] - b_w[i];
            rb_in  = rb_in  & in_lim(rb[i], lim);
            inv_in = inv_in & in_lim(inv[i], lim);
            sum_in = sum_in & in_lim(sum_ab[i], lim);
            add_in = add_in & in_lim(add_ab[i], lim);
            sub_in = sub_in & in_lim(sub_ab[i], lim);
        end
    end

    always_comb
    begin
        ok  = 1'b0;
        rot = '0;
        for (int i = 0; i < 3; i++)
            res[i] = '0;
        unique case (item.func)
            FUNC_ROTATE: begin
                ok  = arot_ok & b_ok & rb_in;
                res = rb;
            end
            FUNC_APPLY: begin
                ok  = arot_ok & b_ok & a_ok & rb_in & sum_in;
                res = sum_ab;
            end
            FUNC_COMPOSE: begin
                ok  = arot_ok & brot_ok & b_ok & a_ok & rb_in & sum_in;
                res = sum_ab;
                rot = rot_index(rot_axis(rot_a, rot_b.x), rot_axis(rot_a, rot_b.y));
            end
            FUNC_INVERSE: begin
                ok  = arot_ok & a_ok & inv_in;
                res = inv;
                rot = rot_index(rot_t_a.x, rot_t_a.y);
            end
            FUNC_ADD: begin
                ok  = a_ok & b_ok & add_in;
                res = add_ab;
            end
            FUNC_SUB: begin
                ok  = a_ok & b_ok & sub_in;
                res = sub_ab;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign rx = res[0][COORD_BITS-1:0];
    assign ry = res[1][COORD_BITS-1:0];
    assign rz = res[2][COORD_BITS-1:0];

    // a failed item reports all zeros
    assign result.ok  = ok;
    assign result.x   = ok ? PORT_BITS'(rx) : '0;
    assign result.y   = ok ? PORT_BITS'(ry) : '0;
    assign result.z   = ok ? PORT_BITS'(rz) : '0;
    assign result.rot = ok ? rot : '0;

endmodule

// ----- src/cube_rotation_grid_transform_unit_core.sv -----
// top level of the cube rotation transform unit: limit register, input stage,
// datapath and result register; depends on crgt_pkg, crgt_in_stage, crgt_compute
`timescale 1ns / 1ps

// Integer 3D grid transforms under the 24 proper cube rotations: rotate, apply
// transform, compose, inverse, add and subtract. An item is taken whenever start
// is high; busy is never raised, so one item can enter every clock cycle. Each
// item gives exactly one result, shown for one cycle with done high, once the
// item has passed the input register, then the result register after a single
// mux-and-add pass. The receiver cannot stall the result, so it must take done
// when it comes. ok low marks an invalid operand, unused func or a coordinate
// beyond max_coordinate; all result fields are zero then. Write max_coordinate
// through cfg_we / cfg_wdata only while no item is in flight.
module cube_rotation_grid_transform_unit_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cfg_we,
    input  logic [crgt_pkg::LIM_BITS-1:0]  cfg_wdata,
    input  logic [2:0]                     func,
    input  logic signed [31:0]             a_x,
    input  logic signed [31:0]             a_y,
    input  logic signed [31:0]             a_z,
    input  logic [7:0]                     a_rot,
    input  logic signed [31:0]             b_x,
    input  logic signed [31:0]             b_y,
    input  logic signed [31:0]             b_z,
    input  logic [7:0]                     b_rot,
    output logic                           done,
    output logic                           ok,
    output logic signed [31:0]             out_x,
    output logic signed [31:0]             out_y,
    output logic signed [31:0]             out_z,
    output logic [4:0]                     out_rot
);
    import crgt_pkg::*;

    logic [LIM_BITS-1:0] max_coord_reg;
    logic                done_reg;
    result_t             result_reg;
    result_t             result_next;
    item_t               item_in;
    item_t               item_q;
    logic                accept;
    logic                stage_valid;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign item_in.func  = func;
    assign item_in.a[0]  = a_x[COORD_BITS-1:0];
    assign item_in.a[1]  = a_y[COORD_BITS-1:0];
    assign item_in.a[2]  = a_z[COORD_BITS-1:0];
    assign item_in.a_rot = a_rot;
    assign item_in.b[0]  = b_x[COORD_BITS-1:0];
    assign item_in.b[1]  = b_y[COORD_BITS-1:0];
    assign item_in.b[2]  = b_z[COORD_BITS-1:0];
    assign item_in.b_rot = b_rot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_coord_reg <= '1;
        else if (cfg_we)
            max_coord_reg <= cfg_wdata;
    end

    crgt_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item_in),
        .valid  (stage_valid),
        .item_q (item_q)
    );

    crgt_compute u_compute (
        .item      (item_q),
        .max_coord (max_coord_reg),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stage_valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid)
            result_reg <= result_next;
    end

    assign done    = done_reg;
    assign ok      = result_reg.ok;
    assign out_x   = result_reg.x;
    assign out_y   = result_reg.y;
    assign out_z   = result_reg.z;
    assign out_rot = result_reg.rot;

endmodule

// ----- src/crgt_checker.sv -----
// port-level checker for the cube rotation transform unit, bound to the top level
// depends on cube_rotation_grid_transform_unit_core_macros.svh
`timescale 1ns / 1ps
`include "cube_rotation_grid_transform_unit_core_macros.svh"

module crgt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               ok,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z,
    input logic [4:0]         out_rot
);

    // every accepted item yields a result, and nothing else does
    `CRGT_ASSERT_IMPL(a_result_follows, start && !busy, ##2 done, "missing result")
    `CRGT_ASSERT_IMPL(a_no_spurious, !(start && !busy), ##2 !done, "result with no item")
    `CRGT_ASSERT_IMPL(a_fail_zero, done && !ok, out_x == 0 && out_y == 0 && out_z == 0 && out_rot == 0, "failed result not cleared")
    `CRGT_ASSERT_IMPL(a_ok_legal, done && ok, out_rot < 5'd24 && out_x != 32'sh80000000 && out_y != 32'sh80000000 && out_z != 32'sh80000000, "illegal good result")

endmodule

bind cube_rotation_grid_transform_unit_core crgt_checker u_crgt_checker (.*);
